@@ src/mono_bitmap_to_page_framebuffer_unit_assert.svh @@
// Assertion macros used by the framebuffer blit controller.
// Self-contained; define ASSERT_OFF to compile the checks away.
`ifndef MONO_BITMAP_TO_PAGE_FRAMEBUFFER_UNIT_ASSERT_SVH
`define MONO_BITMAP_TO_PAGE_FRAMEBUFFER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MBPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framebuffer unit: assertion failed");
`define MBPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framebuffer unit: assertion failed");
`else
`define MBPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MBPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/mbpf_pkg.sv @@
// Shared types and constants of the framebuffer blit unit.
// No dependencies; used by the controller, the datapath and the top level.
package mbpf_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;
  localparam int unsigned STORE_DEPTH       = 1024;
  localparam int unsigned ADDR_W            = $clog2(STORE_DEPTH);
  localparam int unsigned IDX_W             = 14;

  typedef enum logic [1:0] {
    FUNC_BLIT    = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_PIXEL   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_HEIGHT   = 2'd0,
    CFG_WIDTH    = 2'd1,
    CFG_ORIGIN_X = 2'd2,
    CFG_ORIGIN_Y = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       capture;
    logic       restart;
    logic       rd_en;
    logic       rd_pix;
    logic       wr_en;
    logic       blit_step;
    logic       clr_we;
    logic       src_blit;
    logic [2:0] bit_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_sts_t;

endpackage

@@ src/mbpf_ctrl.sv @@
// Sequencer of the framebuffer blit unit: clearing pass, per-pixel
// read-modify-write steps and byte reads. Depends on mbpf_pkg.
`include "mono_bitmap_to_page_framebuffer_unit_assert.svh"

module mbpf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mbpf_pkg::func_e    func_i,
  input  mbpf_pkg::ctrl_sts_t sts_i,
  output mbpf_pkg::ctrl_cmd_t cmd_o,
  output logic               read_valid_o
);
  import mbpf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ
  } state_e;

  state_e     state_q;
  logic [2:0] bit_q;
  logic       blit_q;
  logic       valid_q;
  logic       accept;

  assign busy         = (state_q != ST_IDLE);
  assign accept       = start && (state_q == ST_IDLE);
  assign read_valid_o = valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.restart   = accept && (func_i == FUNC_RESTART);
    cmd_o.rd_en     = (state_q == ST_PIX_RD) || (state_q == ST_READ);
    cmd_o.rd_pix    = (state_q == ST_PIX_RD);
    cmd_o.wr_en     = (state_q == ST_PIX_WR);
    cmd_o.blit_step = (state_q == ST_PIX_WR) && blit_q && (&bit_q);
    cmd_o.clr_we    = (state_q == ST_CLEAR);
    cmd_o.src_blit  = blit_q;
    cmd_o.bit_idx   = bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      bit_q   <= '0;
      blit_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_READ);
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            bit_q <= '0;
            case (func_i)
              FUNC_BLIT: begin
                blit_q  <= 1'b1;
                state_q <= ST_PIX_RD;
              end
              FUNC_PIXEL: begin
                blit_q  <= 1'b0;
                state_q <= ST_PIX_RD;
              end
              FUNC_READ: begin
                state_q <= ST_READ;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PIX_RD: begin
          state_q <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          // A blit byte walks all eight pixels; a single pixel ends here.
          if (blit_q && !(&bit_q)) begin
            bit_q   <= bit_q + 3'd1;
            state_q <= ST_PIX_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MBPF_ASSERT_NXT(a_read_strobe, clk_i, rst_ni, state_q == ST_READ, valid_q)
  `MBPF_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, valid_q, !valid_q)
  `MBPF_ASSERT_IMP(a_wr_after_rd, clk_i, rst_ni, state_q == ST_PIX_WR, $past(state_q) == ST_PIX_RD)
  `MBPF_ASSERT_IMP(a_no_step_single, clk_i, rst_ni, cmd_o.blit_step, cmd_o.wr_en && blit_q)

endmodule

@@ src/mbpf_dpath.sv @@
// Datapath of the framebuffer blit unit: registers, blit counters, pixel
// address logic and the page-organized frame store. Depends on mbpf_pkg.
module mbpf_dpath #(
  parameter int unsigned SCREEN_WIDTH  = mbpf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mbpf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbpf_pkg::ctrl_cmd_t          cmd_i,
  output mbpf_pkg::ctrl_sts_t          sts_o,
  input  logic                         cfg_we_i,
  input  mbpf_pkg::cfg_idx_e           cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic [7:0]                   bitmap_byte_i,
  input  logic [7:0]                   pixel_x_i,
  input  logic [7:0]                   pixel_y_i,
  input  logic                         pixel_on_i,
  input  logic [mbpf_pkg::ADDR_W-1:0]  read_address_i,
  output logic [7:0]                   read_data_o
);
  import mbpf_pkg::*;

  logic [7:0] height_q, width_q, origin_x_q, origin_y_q;
  logic [7:0] row_q;
  logic [4:0] col_q;
  logic [7:0] byte_q, px_q, py_q;
  logic       on_q;
  logic [ADDR_W-1:0] raddr_q;
  logic [ADDR_W-1:0] clr_q;
  logic [7:0] rdata_q;
  logic [7:0] mem [STORE_DEPTH];

  logic [7:0]       cx;
  logic [7:0]       pix_x, pix_y;
  logic             pix_on, pix_ok, in_screen;
  logic [IDX_W-1:0] idx_full;
  logic [ADDR_W-1:0] pix_addr, rd_addr;
  logic [7:0]       mask, new_byte;
  logic [5:0]       row_bytes;
  logic             empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= '0;
      width_q    <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEIGHT:   height_q   <= cfg_data_i;
        CFG_WIDTH:    width_q    <= cfg_data_i;
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign empty     = (width_q == 8'd0) || (height_q == 8'd0);
  assign row_bytes = 6'(({1'b0, width_q} + 9'd7) >> 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i || cmd_i.restart) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.blit_step) begin
      if (empty) begin
        row_q <= '0;
        col_q <= '0;
      end else if ({1'b0, col_q} + 6'd1 >= row_bytes) begin
        col_q <= '0;
        if ({1'b0, row_q} + 9'd1 >= {1'b0, height_q}) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + 8'd1;
        end
      end else begin
        col_q <= col_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q  <= bitmap_byte_i;
      px_q    <= pixel_x_i;
      py_q    <= pixel_y_i;
      on_q    <= pixel_on_i;
      raddr_q <= read_address_i;
    end
  end

  // Pixel coordinates: bitmap pixel under the blit counters, or the
  // captured single pixel. Sums wrap at eight bits.
  assign cx = {col_q, cmd_i.bit_idx};

  always_comb begin
    if (cmd_i.src_blit) begin
      pix_x  = origin_x_q + cx;
      pix_y  = origin_y_q + row_q;
      pix_on = byte_q[3'd7 - cmd_i.bit_idx];
    end else begin
      pix_x  = px_q;
      pix_y  = py_q;
      pix_on = on_q;
    end
  end

  assign idx_full  = IDX_W'(pix_x) + IDX_W'(pix_y[7:3]) * IDX_W'(SCREEN_WIDTH);
  assign in_screen = ({1'b0, pix_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, pix_y} < 9'(SCREEN_HEIGHT)) &&
                     (idx_full < IDX_W'(STORE_DEPTH));
  assign pix_ok    = in_screen &&
                     (!cmd_i.src_blit || ((cx < width_q) && (height_q != 8'd0)));
  assign pix_addr  = idx_full[ADDR_W-1:0];
  assign mask      = 8'(1) << pix_y[2:0];
  assign new_byte  = pix_on ? (rdata_q | mask) : (rdata_q & ~mask);
  assign rd_addr   = cmd_i.rd_pix ? pix_addr : raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign sts_o.clr_last = &clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.wr_en && pix_ok) begin
      mem[pix_addr] <= new_byte;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign read_data_o = rdata_q;

endmodule

@@ src/mono_bitmap_to_page_framebuffer_unit.sv @@
// Top level of the monochrome bitmap blit unit with a page-organized
// framebuffer. Depends on mbpf_pkg, mbpf_ctrl and mbpf_dpath.
//
// After reset the unit clears its 1024-byte frame store, one byte a cycle,
// and holds busy high until the clearing pass ends; register writes are
// taken meanwhile. A command is taken when start is high and busy is low.
// Every pixel takes a read and then a write on the single frame store
// port, so a blit byte walks all eight pixels in turn and a single pixel
// write does one read and one write; a byte read does one read and a
// restart leaves busy low. The read byte appears on read_data_o with
// read_valid_o high for exactly one cycle, once the read state has fetched
// it; it is not held, so the receiver must take it then. Register writes
// clear the blit counters and are meant for idle time.
module mono_bitmap_to_page_framebuffer_unit #(
  parameter int unsigned SCREEN_WIDTH  = mbpf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mbpf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  bitmap_byte_i,
  input  logic [7:0]                  pixel_x_i,
  input  logic [7:0]                  pixel_y_i,
  input  logic                        pixel_on_i,
  input  logic [mbpf_pkg::ADDR_W-1:0] read_address_i,
  output logic [7:0]                  read_data_o,
  output logic                        read_valid_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import mbpf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mbpf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_e'(func_i)),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .read_valid_o (read_valid_o)
  );

  mbpf_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i     (cfg_data_i),
    .bitmap_byte_i  (bitmap_byte_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_on_i     (pixel_on_i),
    .read_address_i (read_address_i),
    .read_data_o    (read_data_o)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for mono_bitmap_to_page_framebuffer_unit.
// Depends on mbpf_pkg; a shadow framebuffer predicts every read transaction,
// and a monitor compares each read_data_o strobe with the oldest prediction.
module tb;
  import mbpf_pkg::*;

  localparam int unsigned SCREEN_W      = 128;
  localparam int unsigned SCREEN_H      = 64;
  localparam int unsigned ITEM_TARGET   = 1650;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_STREAM    = 96;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] func_i = FUNC_BLIT;
  logic [7:0] bitmap_byte_i = '0;
  logic [7:0] pixel_x_i = '0;
  logic [7:0] pixel_y_i = '0;
  logic       pixel_on_i = 1'b0;
  logic [ADDR_W-1:0] read_address_i = '0;
  logic [7:0] read_data_o;
  logic       read_valid_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_HEIGHT;
  logic [7:0] cfg_data_i = '0;

  mono_bitmap_to_page_framebuffer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .bitmap_byte_i  (bitmap_byte_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_on_i     (pixel_on_i),
    .read_address_i (read_address_i),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the framebuffer, the blit registers and the blit counters.
  logic [7:0] frame_copy [STORE_DEPTH];
  logic [7:0] bmp_h = '0;
  logic [7:0] bmp_w = '0;
  logic [7:0] org_x = '0;
  logic [7:0] org_y = '0;
  logic [7:0] row_cnt = '0;
  logic [4:0] col_cnt = '0;

  logic [7:0] expected_reads [$];
  logic [7:0] want;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned blits_sent = 0;
  int unsigned reads_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned cycles = 0;
  bit steady = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && read_valid_o === 1'b1) begin
      if (expected_reads.size() == 0) begin
        $error("read_data: no read pending, got %02h", read_data_o);
        errors++;
      end else begin
        want = expected_reads.pop_front();
        reads_checked++;
        if (read_data_o !== want) begin
          $error("read_data: expected %02h, actual %02h", want, read_data_o);
          errors++;
        end
      end
    end
  end

  function automatic void plot(input logic [7:0] x, input logic [7:0] y, input logic on);
    int unsigned idx;
    if (x >= SCREEN_W || y >= SCREEN_H) return;
    idx = x + (y >> 3) * SCREEN_W;
    if (idx >= STORE_DEPTH) return;
    frame_copy[idx][y[2:0]] = on;
  endfunction

  function automatic void draw_blit_byte(input logic [7:0] data);
    int unsigned bytes_per_row;
    int unsigned cx;
    int unsigned b;
    logic [7:0] sx;
    logic [7:0] sy;
    if (bmp_w == 0 || bmp_h == 0) begin
      row_cnt = '0;
      col_cnt = '0;
      return;
    end
    bytes_per_row = (bmp_w + 7) >> 3;
    for (b = 0; b < 8; b++) begin
      cx = col_cnt * 8 + b;
      // Padding bits past the bitmap width are dropped.
      if (cx < bmp_w) begin
        sx = 8'(org_x + cx);
        sy = org_y + row_cnt;
        plot(sx, sy, data[7 - b]);
      end
    end
    if (col_cnt + 1 >= bytes_per_row) begin
      col_cnt = '0;
      if (row_cnt + 1 >= bmp_h) row_cnt = '0;
      else row_cnt = row_cnt + 8'd1;
    end else begin
      col_cnt = col_cnt + 5'd1;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly addresses covering the current bitmap area, sometimes anywhere.
  function automatic logic [ADDR_W-1:0] region_addr();
    logic [ADDR_W-1:0] a;
    logic [7:0] col;
    logic [7:0] row;
    a = ADDR_W'($urandom);
    if ($urandom_range(0, 3) == 0) return a;
    col = 8'(org_x + $urandom_range(0, bmp_w));
    row = 8'(org_y + $urandom_range(0, bmp_h));
    return {row[5:3], col[6:0]};
  endfunction

  // Holds one transaction until it is taken, updates the prediction, then idles.
  task automatic issue(input func_e fn, input logic [7:0] data, input logic [7:0] x,
                       input logic [7:0] y, input logic on, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    start          <= 1'b1;
    func_i         <= fn;
    bitmap_byte_i  <= data;
    pixel_x_i      <= x;
    pixel_y_i      <= y;
    pixel_on_i     <= on;
    read_address_i <= addr;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    case (fn)
      FUNC_BLIT: begin
        draw_blit_byte(data);
        blits_sent++;
      end
      FUNC_READ: expected_reads.push_back(frame_copy[addr]);
      FUNC_RESTART: begin
        row_cnt = '0;
        col_cnt = '0;
      end
      FUNC_PIXEL: plot(x, y, on);
      default: ;
    endcase
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic blit(input logic [7:0] data);
    issue(FUNC_BLIT, data, 8'($urandom), 8'($urandom), 1'($urandom), ADDR_W'($urandom));
  endtask

  task automatic read_at(input logic [ADDR_W-1:0] addr);
    issue(FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), addr);
  endtask

  task automatic put_px(input logic [7:0] x, input logic [7:0] y, input logic on);
    issue(FUNC_PIXEL, 8'($urandom), x, y, on, ADDR_W'($urandom));
  endtask

  task automatic restart_blit();
    issue(FUNC_RESTART, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
          ADDR_W'($urandom));
  endtask

  // Drains all pending reads and lets any blit in flight finish.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy !== 1'b0 || expected_reads.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the registers selected by mask; called while the unit is idle, and once while it clears its store.
  task automatic write_regs(input logic [3:0] mask, input logic [7:0] h, input logic [7:0] w,
                            input logic [7:0] x, input logic [7:0] y);
    int i;
    cfg_idx_e idx;
    logic [7:0] v;
    for (i = 0; i < 4; i++) begin
      if (mask[i]) begin
        idx = cfg_idx_e'(i);
        case (idx)
          CFG_HEIGHT:   v = h;
          CFG_WIDTH:    v = w;
          CFG_ORIGIN_X: v = x;
          default:      v = y;
        endcase
        cfg_we_i    <= 1'b1;
        cfg_index_i <= idx;
        cfg_data_i  <= v;
        @(posedge clk_i);
        case (idx)
          CFG_HEIGHT:   bmp_h = v;
          CFG_WIDTH:    bmp_w = v;
          CFG_ORIGIN_X: org_x = v;
          default:      org_y = v;
        endcase
        row_cnt = '0;
        col_cnt = '0;
        reg_writes++;
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_pixel_corners();
    put_px(8'd0, 8'd0, 1'b1);
    put_px(8'd127, 8'd63, 1'b1);
    put_px(8'd128, 8'd5, 1'b1);
    put_px(8'd5, 8'd64, 1'b1);
    put_px(8'd255, 8'd255, 1'b1);
    put_px(8'd127, 8'd0, 1'b1);
    put_px(8'd0, 8'd63, 1'b1);
    read_at(10'd0);
    read_at(10'd127);
    read_at(10'd1023);
    read_at(10'd896);
    put_px(8'd0, 8'd0, 1'b0);
    read_at(10'd0);
  endtask

  // Bitmap hangs off the right and bottom edges; columns wrap past 255.
  task automatic test_blit_wrap_and_padding();
    settle();
    write_regs(4'hF, 8'd3, 8'd10, 8'd250, 8'd62);
    blit(8'hFF);
    blit(8'hFF);
    blit(8'hA5);
    blit(8'hC0);
    blit(8'hFF);
    restart_blit();
    blit(8'h00);
    read_at(10'd896);
    read_at(10'd899);
    read_at(10'd900);
  endtask

  task automatic test_empty_bitmap();
    settle();
    write_regs(4'b0010, 8'd0, 8'd0, 8'd0, 8'd0);
    blit(8'hFF);
    read_at(10'd0);
  endtask

  task automatic test_random_bitmaps();
    logic [7:0] h;
    logic [7:0] w;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] data;
    logic [3:0] mask;
    int unsigned total;
    int unsigned nbytes;
    int unsigned k;
    int unsigned r;
    int unsigned nreads;
    while (items_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 9))
        0: h = 8'd0;
        1: h = 8'd255;
        2: h = 8'd1;
        default: h = 8'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 9))
        0: w = 8'd0;
        1: w = 8'd255;
        2: w = 8'd1;
        default: w = 8'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 7))
        0: x = 8'd0;
        1: x = 8'd255;
        2: x = 8'd127;
        3: x = 8'd128;
        default: x = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: y = 8'd0;
        1: y = 8'd255;
        2: y = 8'd63;
        3: y = 8'd64;
        default: y = 8'($urandom_range(0, 70));
      endcase
      mask = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'hF;
      write_regs(mask, h, w, x, y);
      steady = ($urandom_range(0, 4) == 0);

      // Stream the whole bitmap when it is small, with a few extra bytes now
      // and then so the counters wrap back to the first row.
      total = bmp_h * ((bmp_w + 7) >> 3);
      if (total == 0) total = 2;
      nbytes = (total > MAX_STREAM) ? MAX_STREAM : total;
      if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, 8);
      k = 0;
      while (k < nbytes) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          case ($urandom_range(0, 7))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom);
          endcase
          blit(data);
          k++;
        end else if (r < 88) begin
          read_at(region_addr());
        end else if (r < 95) begin
          put_px(8'($urandom),
                 $urandom_range(0, 1) ? 8'($urandom_range(0, 70)) : 8'($urandom),
                 1'($urandom));
        end else if (r < 97) begin
          restart_blit();
        end else begin
          settle();
        end
      end
      nreads = $urandom_range(4, 16);
      repeat (nreads) read_at(region_addr());
      steady = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) frame_copy[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Registers are taken while the unit clears its store.
    write_regs(4'hF, 8'd0, 8'd0, 8'd0, 8'd0);
    test_pixel_corners();
    test_blit_wrap_and_padding();
    test_empty_bitmap();
    test_random_bitmaps();
    settle();
    $display("%0d transactions sent: %0d blit bytes, %0d reads checked, %0d register writes",
             items_sent, blits_sent, reads_checked, reg_writes);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
